@@ hdl/fafc_pkg.sv @@
// Shared sizes, request codes, sequencer states and control structs of the FIFO cache.
package fafc_pkg;

  localparam int LINES          = 8;
  localparam int WORDS_PER_LINE = 4;
  localparam int ADDR_BITS      = 32;
  localparam int DATA_BITS      = 32;

  localparam int OFF_BITS    = $clog2(WORDS_PER_LINE);
  localparam int OFF_W       = (OFF_BITS > 0) ? OFF_BITS : 1;
  localparam int TAG_BITS    = ADDR_BITS - OFF_BITS;
  localparam int LINE_W      = $clog2(LINES);
  localparam int CNT_W       = $clog2(LINES + 1);
  localparam int DEPTH_WORDS = LINES * WORDS_PER_LINE;
  localparam int WADDR_W     = $clog2(DEPTH_WORDS);

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_COPY,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                start;
    logic [TAG_BITS-1:0] tag;
  } scan_cmd_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [LINE_W-1:0]   line;
  } scan_stat_t;

  typedef struct packed {
    logic                we;
    logic [LINE_W-1:0]   line;
    logic [TAG_BITS-1:0] tag;
  } tag_wr_t;

endpackage

@@ hdl/fully_associative_fifo_cache.sv @@
// Top level of the fully associative cache with FIFO replacement.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-----------------------
//  input   | in_req_type in_address in_write_data in_fill_last | in_valid / in_ready
//  result  | out_hit out_read_data out_installed           | out_valid / out_ready
//
// One word is worked on at a time. A non-final fill word or an unknown request goes
// straight to the result state; a read, write or final fill word walks the valid
// lines through the one tag comparator, one line a cycle, and a read hit then waits
// on the registered read of the data memory. Installing a line copies the fill
// buffer into the data memory, one word a cycle. Reset empties the cache; a stalled
// result holds the block.
module fully_associative_fifo_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic        in_fill_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_read_data,
  output logic        out_installed
);
  import fafc_pkg::*;

  state_t               state_r, state_nxt;
  logic [1:0]           req_r,      req_nxt;
  logic [ADDR_BITS-1:0] addr_r,     addr_nxt;
  logic [DATA_BITS-1:0] wdata_r,    wdata_nxt;
  logic [DATA_BITS-1:0] fill_buf_r   [WORDS_PER_LINE];
  logic [DATA_BITS-1:0] fill_buf_nxt [WORDS_PER_LINE];
  logic [OFF_W-1:0]     fill_idx_r, fill_idx_nxt;
  logic [OFF_W-1:0]     copy_idx_r, copy_idx_nxt;
  logic [CNT_W-1:0]     vcount_r,   vcount_nxt;
  logic [LINE_W-1:0]    ins_ptr_r,  ins_ptr_nxt;
  logic [WADDR_W-1:0]   rd_addr_r,  rd_addr_nxt;
  logic                 res_hit_r,  res_hit_nxt;
  logic                 res_inst_r, res_inst_nxt;
  logic                 res_rd_r,   res_rd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r,  out_hit_nxt;
  logic [31:0]          out_rdata_r, out_rdata_nxt;
  logic                 out_inst_r, out_inst_nxt;

  logic                 accept;
  logic                 go_scan;
  logic                 out_free;
  logic [ADDR_BITS-1:0] in_addr;
  logic [OFF_W-1:0]     offset;
  logic                 offset_ok;
  logic                 copy_last;
  scan_cmd_t            scan_cmd;
  scan_stat_t           scan_stat;
  tag_wr_t              tag_wr;
  logic                 dram_we;
  logic [WADDR_W-1:0]   dram_waddr;
  logic [DATA_BITS-1:0] dram_wdata;
  logic [DATA_BITS-1:0] dram_rdata;

  localparam logic [ADDR_BITS-1:0] OFF_MASK = ADDR_BITS'((64'd1 << OFF_BITS) - 64'd1);

  function automatic logic [WADDR_W-1:0] word_addr(input logic [LINE_W-1:0] line,
                                                   input logic [OFF_W-1:0]  off);
    return WADDR_W'(WADDR_W'(line) * WADDR_W'(WORDS_PER_LINE)) + WADDR_W'(off);
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_addr   = ADDR_BITS'(in_address);
  assign go_scan   = (in_req_type == REQ_READ) || (in_req_type == REQ_WRITE) ||
                     ((in_req_type == REQ_FILL) && in_fill_last);
  assign out_free  = !out_valid_r || out_ready;
  assign offset    = OFF_W'(addr_r & OFF_MASK);
  assign offset_ok = (32'(offset) < WORDS_PER_LINE);
  assign copy_last = (copy_idx_r == OFF_W'(WORDS_PER_LINE - 1));

  fafc_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (scan_cmd),
    .valid_count (vcount_r),
    .tag_wr      (tag_wr),
    .stat        (scan_stat)
  );

  fafc_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (rd_addr_r),
    .rdata (dram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = go_scan ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          if (req_r == REQ_FILL) begin
            state_nxt = scan_stat.found ? ST_RESP : ST_COPY;
          end else if ((req_r == REQ_READ) && scan_stat.found && offset_ok) begin
            state_nxt = ST_RDWAIT;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RDWAIT: state_nxt = ST_RESP;
      ST_COPY: begin
        if (copy_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    fill_buf_nxt  = fill_buf_r;
    fill_idx_nxt  = fill_idx_r;
    copy_idx_nxt  = copy_idx_r;
    vcount_nxt    = vcount_r;
    ins_ptr_nxt   = ins_ptr_r;
    rd_addr_nxt   = rd_addr_r;
    res_hit_nxt   = res_hit_r;
    res_inst_nxt  = res_inst_r;
    res_rd_nxt    = res_rd_r;
    out_hit_nxt   = out_hit_r;
    out_rdata_nxt = out_rdata_r;
    out_inst_nxt  = out_inst_r;
    out_valid_nxt = out_valid_r && !out_ready;
    scan_cmd.start = 1'b0;
    scan_cmd.tag   = TAG_BITS'(in_addr >> OFF_BITS);
    tag_wr.we      = 1'b0;
    tag_wr.line    = ins_ptr_r;
    tag_wr.tag     = TAG_BITS'(addr_r >> OFF_BITS);
    dram_we        = 1'b0;
    dram_waddr     = word_addr(ins_ptr_r, copy_idx_r);
    dram_wdata     = fill_buf_r[copy_idx_r];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt        = in_req_type;
          addr_nxt       = in_addr;
          wdata_nxt      = DATA_BITS'(in_write_data);
          res_hit_nxt    = 1'b0;
          res_inst_nxt   = 1'b0;
          res_rd_nxt     = 1'b0;
          scan_cmd.start = go_scan;
          if (in_req_type == REQ_FILL) begin
            fill_buf_nxt[fill_idx_r] = DATA_BITS'(in_write_data);
            if (in_fill_last || (fill_idx_r == OFF_W'(WORDS_PER_LINE - 1))) begin
              fill_idx_nxt = '0;
            end else begin
              fill_idx_nxt = fill_idx_r + 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          res_hit_nxt = scan_stat.found;
          if (req_r == REQ_FILL) begin
            if (!scan_stat.found) begin
              tag_wr.we    = 1'b1;
              copy_idx_nxt = '0;
            end
          end else if (scan_stat.found && offset_ok) begin
            if (req_r == REQ_READ) begin
              rd_addr_nxt = word_addr(scan_stat.line, offset);
              res_rd_nxt  = 1'b1;
            end else begin
              dram_we    = 1'b1;
              dram_waddr = word_addr(scan_stat.line, offset);
              dram_wdata = wdata_r;
            end
          end
        end
      end
      ST_RDWAIT: begin
      end
      ST_COPY: begin
        dram_we      = 1'b1;
        copy_idx_nxt = copy_idx_r + 1'b1;
        if (copy_last) begin
          // The slot just written becomes the newest line; when full it was the oldest.
          ins_ptr_nxt  = (ins_ptr_r == LINE_W'(LINES - 1)) ? '0 : ins_ptr_r + 1'b1;
          vcount_nxt   = (vcount_r < CNT_W'(LINES)) ? vcount_r + 1'b1 : vcount_r;
          res_inst_nxt = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_inst_nxt  = res_inst_r;
          out_rdata_nxt = res_rd_r ? 32'(dram_rdata) : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_idx_r  <= '0;
      vcount_r    <= '0;
      ins_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_idx_r  <= fill_idx_nxt;
      vcount_r    <= vcount_nxt;
      ins_ptr_r   <= ins_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    wdata_r     <= wdata_nxt;
    fill_buf_r  <= fill_buf_nxt;
    copy_idx_r  <= copy_idx_nxt;
    rd_addr_r   <= rd_addr_nxt;
    res_hit_r   <= res_hit_nxt;
    res_inst_r  <= res_inst_nxt;
    res_rd_r    <= res_rd_nxt;
    out_hit_r   <= out_hit_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_inst_r  <= out_inst_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_read_data = out_rdata_r;
  assign out_installed = out_inst_r;

endmodule

@@ hdl/fafc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fafc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fafc_scan.sv @@
// Tag store and the shared tag comparator that walks the valid lines one per cycle.
module fafc_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fafc_pkg::scan_cmd_t          cmd,
  input  logic [fafc_pkg::CNT_W-1:0]   valid_count,
  input  fafc_pkg::tag_wr_t            tag_wr,
  output fafc_pkg::scan_stat_t         stat
);
  import fafc_pkg::*;

  logic                issue_r,    issue_nxt;
  logic [LINE_W-1:0]   rd_idx_r,   rd_idx_nxt;
  logic                cmp_vld_r,  cmp_vld_nxt;
  logic                cmp_last_r, cmp_last_nxt;
  logic [LINE_W-1:0]   cmp_idx_r,  cmp_idx_nxt;
  logic                found_r,    found_nxt;
  logic [LINE_W-1:0]   line_r,     line_nxt;
  logic [TAG_BITS-1:0] tag_r,      tag_nxt;
  logic [TAG_BITS-1:0] tag_rdata;
  logic                match;
  logic                last_issue;

  fafc_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_wr.we),
    .waddr (tag_wr.line),
    .wdata (tag_wr.tag),
    .raddr (rd_idx_r),
    .rdata (tag_rdata)
  );

  // The read data of the tag store lines up with the compare stage registers.
  assign match      = cmp_vld_r && (tag_rdata == tag_r);
  assign last_issue = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == valid_count);

  always_comb begin
    issue_nxt    = issue_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_last_nxt = 1'b0;
    cmp_idx_nxt  = rd_idx_r;
    tag_nxt      = tag_r;
    found_nxt    = found_r;
    line_nxt     = line_r;
    if (match && !found_r) begin
      found_nxt = 1'b1;
      line_nxt  = cmp_idx_r;
    end
    if (cmd.start) begin
      tag_nxt      = cmd.tag;
      found_nxt    = 1'b0;
      rd_idx_nxt   = '0;
      issue_nxt    = (valid_count != '0);
      // With no valid line the search ends at once with a miss.
      cmp_last_nxt = (valid_count == '0);
    end else if (issue_r) begin
      cmp_vld_nxt  = 1'b1;
      cmp_last_nxt = last_issue;
      issue_nxt    = !last_issue;
      rd_idx_nxt   = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r    <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      issue_r    <= issue_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_last_r <= cmp_last_nxt;
      found_r    <= found_nxt;
    end
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    line_r    <= line_nxt;
    tag_r     <= tag_nxt;
  end

  assign stat.done  = cmp_last_r;
  assign stat.found = found_r || match;
  assign stat.line  = (match && !found_r) ? cmp_idx_r : line_r;

endmodule

@@ hdl/fafc_checker.sv @@
// Port-level checks of the FIFO cache and the bind that attaches them to the top level.
module fafc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_read_data,
  input logic        out_installed
);

  // A waiting result word keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_read_data) && $stable(out_installed))
    else $error("result word changed while stalled");

  // A line is only installed when its tag was absent.
  a_inst_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_installed |-> !out_hit)
    else $error("installed together with hit");

  // Read data other than zero only comes from a read hit.
  a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != 32'd0) |-> out_hit && !out_installed)
    else $error("read data without a hit");

  // The block works on one word at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

endmodule

bind fully_associative_fifo_cache fafc_checker u_fafc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hit       (out_hit),
  .out_read_data (out_read_data),
  .out_installed (out_installed)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the fully associative cache with FIFO replacement.
module testbench;
  import fafc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 2 * (LINES + WORDS_PER_LINE + 3) + 10;
  localparam int LONG_STALL   = 200;
  localparam int TAG_POOL     = 24;
  localparam int DIRECTED_ROWS = 24;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        installed;
  } cache_response_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        fill_last;
    logic        typed;
    logic        hit;
    logic [31:0] read_data;
    logic        installed;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [31:0] in_address;
  logic [31:0] in_write_data;
  logic        in_fill_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [31:0] out_read_data;
  logic        out_installed;

  fully_associative_fifo_cache dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_fill_last  (in_fill_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_data (out_read_data),
    .out_installed (out_installed)
  );

  // Mirror of the cache contents, advanced as each word is accepted.
  logic [TAG_BITS-1:0] line_tag   [LINES];
  logic [31:0]         line_data  [LINES][WORDS_PER_LINE];
  logic [31:0]         fill_words [WORDS_PER_LINE];
  int unsigned         lines_valid;
  int unsigned         next_victim;
  int unsigned         fill_slot;

  logic [TAG_BITS-1:0] tag_pool [TAG_POOL];
  cache_response_t     pending_responses [$];
  cache_response_t     oldest;
  directed_row_t       directed_rows [DIRECTED_ROWS];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          long_stall_asks;
  int          long_stalls_served;
  int          stall_left;
  int          errors;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_line(logic [TAG_BITS-1:0] tag);
    for (int i = 0; i < LINES; i++) begin
      if (i < lines_valid && line_tag[i] == tag) return i;
    end
    return LINES;
  endfunction

  function automatic cache_response_t apply_request(logic [1:0] kind, logic [31:0] address,
                                                    logic [31:0] write_data, logic last);
    logic [63:0]         addr;
    logic [31:0]         word;
    logic [TAG_BITS-1:0] tag;
    int                  off;
    int                  line;
    cache_response_t     resp;
    addr = 64'(address) & ((64'd1 << ADDR_BITS) - 64'd1);
    word = 32'(64'(write_data) & ((64'd1 << DATA_BITS) - 64'd1));
    tag  = TAG_BITS'(addr >> OFF_BITS);
    off  = int'(addr & ((64'd1 << OFF_BITS) - 64'd1));
    resp = '0;
    case (kind)
      REQ_READ, REQ_WRITE: begin
        line = find_line(tag);
        if (line < LINES) begin
          resp.hit = 1'b1;
          if (off < WORDS_PER_LINE) begin
            if (kind == REQ_READ) resp.read_data = line_data[line][off];
            else line_data[line][off] = word;
          end
        end
      end
      REQ_FILL: begin
        fill_words[fill_slot] = word;
        fill_slot = (fill_slot + 1) % WORDS_PER_LINE;
        if (last) begin
          fill_slot = 0;
          line = find_line(tag);
          if (line < LINES) begin
            resp.hit = 1'b1;
          end else begin
            line_tag[next_victim] = tag;
            for (int w = 0; w < WORDS_PER_LINE; w++) line_data[next_victim][w] = fill_words[w];
            next_victim = (next_victim + 1) % LINES;
            if (lines_valid < LINES) lines_valid++;
            resp.installed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  // In 45 of 100 picks a tag already held, when any line is valid, so that reads, writes and refills hit.
  function automatic logic [TAG_BITS-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45 && lines_valid > 0) return line_tag[$urandom_range(lines_valid - 1)];
    if (roll < 80) return tag_pool[$urandom_range(TAG_POOL - 1)];
    return TAG_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [31:0] word_address(logic [TAG_BITS-1:0] tag, int off);
    return 32'((64'(tag) << OFF_BITS) | 64'(off));
  endfunction

  task automatic offer_word(input logic [1:0] kind, input logic [31:0] address,
                            input logic [31:0] write_data, input logic last,
                            input logic typed, input cache_response_t typed_response);
    cache_response_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = kind;
    in_address    = address;
    in_write_data = write_data;
    in_fill_last  = last;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(kind, address, write_data, last);
    pending_responses.push_back(typed ? typed_response : predicted);
  endtask

  // The sender lets go of the last word before it waits, so that word is not taken twice.
  task automatic wait_responses_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic(input int words);
    int                  sent;
    int unsigned         roll;
    int unsigned         len_roll;
    int                  len;
    logic                abandon;
    logic [TAG_BITS-1:0] tag;
    sent = 0;
    while (sent < words) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        tag = pick_tag();
        offer_word(REQ_READ, word_address(tag, $urandom_range(WORDS_PER_LINE - 1)), $urandom,
                   1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else if (roll < 58) begin
        tag = pick_tag();
        offer_word(REQ_WRITE, word_address(tag, $urandom_range(WORDS_PER_LINE - 1)), $urandom,
                   1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else if (roll < 90) begin
        // Mostly whole lines; some short, some overlong so the slot index wraps,
        // and now and then a line that never gets its final word.
        tag      = pick_tag();
        len_roll = $urandom_range(99);
        if (len_roll < 70) len = WORDS_PER_LINE;
        else if (len_roll < 85) len = $urandom_range(WORDS_PER_LINE, 1);
        else len = $urandom_range(2 * WORDS_PER_LINE - 1, WORDS_PER_LINE + 1);
        abandon = (len_roll >= 96);
        for (int w = 0; w < len; w++) begin
          offer_word(REQ_FILL, word_address(tag, w % WORDS_PER_LINE), $urandom,
                     (w == len - 1) && !abandon, 1'b0, '0);
          sent++;
        end
      end else if (roll < 94) begin
        offer_word(REQ_UNUSED, $urandom, $urandom, 1'($urandom_range(1)), 1'b0, '0);
      end else begin
        offer_word(2'($urandom_range(2)), $urandom, $urandom, 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_READ;
    in_address    = '0;
    in_write_data = '0;
    in_fill_last  = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 58;
    long_stall_asks = 0;
    for (int i = 0; i < LINES; i++) begin
      line_tag[i] = '0;
      for (int w = 0; w < WORDS_PER_LINE; w++) line_data[i][w] = '0;
    end
    for (int w = 0; w < WORDS_PER_LINE; w++) fill_words[w] = '0;
    lines_valid = 0;
    next_victim = 0;
    fill_slot   = 0;
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_BITS'({$urandom, $urandom});

    // The first fill is a whole line, so no installed word is ever left unwritten.
    directed_rows = '{
      '{REQ_READ,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0002, 32'hA5A5_A5A5, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0003, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0, 32'h0, 1'b1},
      '{REQ_READ,   32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_READ,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_WRITE,  32'h0000_0001, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_READ,   32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_READ,   32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'hFFFF_FFFC, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h4000_0004, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0010, 32'h0F0F_0F0F, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h0000_0020, 32'hF0F0_F0F0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h7FFF_FFF8, 32'h3333_3333, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'h5555_5554, 32'hCCCC_CCCC, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_FILL,   32'hAAAA_AAA8, 32'h7777_7777, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_READ,   32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_WRITE,  32'hFFFF_FFFD, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{REQ_READ,   32'hAAAA_AAA8, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].req_type, directed_rows[i].address,
                 directed_rows[i].write_data, directed_rows[i].fill_last, directed_rows[i].typed,
                 cache_response_t'{directed_rows[i].hit, directed_rows[i].read_data,
                                   directed_rows[i].installed});
    wait_responses_drained();

    random_traffic(300);
    // The receiver now holds off long enough for the cache to back up its input.
    long_stall_asks++;
    random_traffic(270);
    wait_responses_drained();

    send_idle_pct = 58;
    recv_idle_pct = 32;
    random_traffic(565);
    wait_responses_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(565);
    @(negedge clk);
    in_valid = 1'b0;

    wait_responses_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("[fully_associative_fifo_cache] OK");
    end else begin
      $display("[fully_associative_fifo_cache] ERROR");
    end
    $finish;
  end

  initial begin
    out_ready          = 1'b0;
    long_stalls_served = 0;
    stall_left         = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (long_stall_asks != long_stalls_served) begin
        long_stalls_served++;
        stall_left = LONG_STALL - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial errors = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $error("result word arrived with nothing outstanding");
        errors++;
      end else begin
        oldest = pending_responses.pop_front();
        if (out_hit !== oldest.hit) begin
          $error("out_hit: expected %0d, got %0d", oldest.hit, out_hit);
          errors++;
        end
        if (out_read_data !== oldest.read_data) begin
          $error("out_read_data: expected %h, got %h", oldest.read_data, out_read_data);
          errors++;
        end
        if (out_installed !== oldest.installed) begin
          $error("out_installed: expected %0d, got %0d", oldest.installed, out_installed);
          errors++;
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[fully_associative_fifo_cache] ERROR");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/fafc_pkg.sv
hdl/fafc_ram.sv
hdl/fafc_scan.sv
hdl/fully_associative_fifo_cache.sv
hdl/fafc_checker.sv
tb/testbench.sv
